// ----- hdl/crtf_pkg.sv -----
`timescale 1ns / 1ps

package crtf_pkg;

  // widths fixed by the item format
  localparam int KIND_W   = 3;
  localparam int CNT_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 3;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 56;

  // largest slot count the 5-bit register can ask for
  localparam int SLOT_CNT_MAX = 31;

  // operation kinds
  localparam logic [KIND_W-1:0] K_CLAIM_SPACE    = 3'd0;
  localparam logic [KIND_W-1:0] K_RELEASE_TOKENS = 3'd1;
  localparam logic [KIND_W-1:0] K_CLAIM_TOKEN    = 3'd2;
  localparam logic [KIND_W-1:0] K_RELEASE_SPACES = 3'd3;
  localparam logic [KIND_W-1:0] K_WRITE          = 3'd4;
  localparam logic [KIND_W-1:0] K_READ           = 3'd5;
  localparam logic [KIND_W-1:0] K_STORE          = 3'd6;
  localparam logic [KIND_W-1:0] K_LOAD           = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_TOKEN    = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVER_REL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLAIMS_OUT  = 3'd4;

  // result fields held while the token memory read completes
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] claimed_slot;
    logic              use_rdata;
    logic [CNT_W-1:0]  free_spaces;
    logic [CNT_W-1:0]  available_tokens;
  } crtf_res_t;

endpackage

// ----- hdl/claim_release_token_fifo.sv -----
`timescale 1ns / 1ps

// Circular token fifo with separate claim and release phases. A producer claims free
// slots one at a time (the granted slot index comes back in the result), fills them with
// store slot operations and releases them as tokens; a consumer claims tokens, reads them
// with load slot and releases the spaces. Plain write and read move one token and are
// refused with a status while claims of their own side are outstanding. A claim or plain
// access that would block returns a full or empty status instead and leaves the state
// alone. Every result reports free spaces and available tokens after the operation.
// Writing slot_count empties the fifo (positions and counts to zero, tokens kept); the
// slot count in use is 1 for a register value of 0 and is capped at the built depth.
// Counters and positions live in flip-flops; the tokens live in a single-port-per-side
// synchronous memory with a registered read, so each item passes the counter update and
// memory access, then result capture in the output register, and a new item is
// taken every cycle as long as results are drained. Read-after-write to the same slot
// needs no forwarding since the write lands before the following item's read.
module claim_release_token_fifo
  import crtf_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int TOKEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration: slot_count
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CNT_W-1:0]    cfg_data,
  // operation input
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,   // release_count[4:0], slot_index[8:5], write_data[40:9]
  input  logic [KIND_W-1:0]   in_tuser,   // kind[2:0]
  // result output
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata   // status[2:0], claimed_slot[6:3], read_data[38:7],
                                          // free_spaces[43:39], available_tokens[48:44]
);

  // only as many slots as the slot count register can reach are ever addressed
  localparam int MEM_DEPTH = (DEPTH < SLOT_CNT_MAX) ? DEPTH : SLOT_CNT_MAX;
  localparam int AW        = $clog2(MEM_DEPTH);
  // tokens arrive on a 32-bit field, so wider tokens store no more than that
  localparam int SB        = (TOKEN_BITS < DATA_W) ? TOKEN_BITS : DATA_W;
  localparam logic [CNT_W-1:0] NMAX = CNT_W'(MEM_DEPTH);

  // control state
  logic [CNT_W-1:0] slot_cnt_r;
  logic [CNT_W-1:0] wpos_r, wpos_nxt;
  logic [CNT_W-1:0] rpos_r, rpos_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cspace_r, cspace_nxt;
  logic [CNT_W-1:0] ctoken_r, ctoken_nxt;

  // token memory
  logic [SB-1:0]    mem [MEM_DEPTH];
  logic [SB-1:0]    mem_q_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;

  // result pipeline
  logic             p1_valid_r;
  crtf_res_t        p1_r, p1_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_load;
  logic             in_acc;
  logic             cfg_acc;

  // input fields
  logic [KIND_W-1:0] kind;
  logic [CNT_W-1:0]  rel_cnt;
  logic [SLOT_W-1:0] slot_idx;
  logic [DATA_W-1:0] wdata;

  logic [CNT_W-1:0]  n;
  logic [CNT_W:0]    wsum, rsum, wadv, radv;
  logic [CNT_W-1:0]  wgrant, rgrant, wrel, rrel;
  logic [CNT_W:0]    fill_space;
  logic              slot_ok;

  // one conditional subtract: one operand is below n, the other at most n
  function automatic logic [CNT_W-1:0] wrap(input logic [CNT_W:0] s, input logic [CNT_W-1:0] m);
    logic [CNT_W:0] d;
    d = s - {1'b0, m};
    wrap = (s >= {1'b0, m}) ? d[CNT_W-1:0] : s[CNT_W-1:0];
  endfunction

  assign kind     = in_tuser;
  assign rel_cnt  = in_tdata[4:0];
  assign slot_idx = in_tdata[8:5];
  assign wdata    = in_tdata[40:9];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;

  // output register parts the result side from the counter stage
  assign out_load  = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  // slot count in use
  always_comb begin
    if (slot_cnt_r == '0) begin
      n = CNT_W'(1);
    end else if (slot_cnt_r > NMAX) begin
      n = NMAX;
    end else begin
      n = slot_cnt_r;
    end
  end

  assign wsum       = {1'b0, wpos_r} + {1'b0, cspace_r};
  assign rsum       = {1'b0, rpos_r} + {1'b0, ctoken_r};
  assign wadv       = {1'b0, wpos_r} + {1'b0, rel_cnt};
  assign radv       = {1'b0, rpos_r} + {1'b0, rel_cnt};
  assign wgrant     = wrap(wsum, n);
  assign rgrant     = wrap(rsum, n);
  assign wrel       = wrap(wadv, n);
  assign rrel       = wrap(radv, n);
  assign fill_space = {1'b0, fill_r} + {1'b0, cspace_r};
  assign slot_ok    = {1'b0, slot_idx} < n;

  // operation decode: counter update and memory access request
  always_comb begin
    wpos_nxt   = wpos_r;
    rpos_nxt   = rpos_r;
    fill_nxt   = fill_r;
    cspace_nxt = cspace_r;
    ctoken_nxt = ctoken_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = wpos_r[AW-1:0];
    mem_raddr  = rpos_r[AW-1:0];
    p1_nxt     = '0;
    case (kind)
      K_CLAIM_SPACE: begin
        if (fill_space >= {1'b0, n}) begin
          p1_nxt.status = ST_NO_SPACE;
        end else begin
          p1_nxt.claimed_slot = wgrant[SLOT_W-1:0];
          cspace_nxt          = cspace_r + 1'b1;
        end
      end
      K_RELEASE_TOKENS: begin
        if (rel_cnt > cspace_r) begin
          p1_nxt.status = ST_OVER_REL;
        end else begin
          cspace_nxt = cspace_r - rel_cnt;
          fill_nxt   = fill_r + rel_cnt;
          wpos_nxt   = wrel;
        end
      end
      K_CLAIM_TOKEN: begin
        if (ctoken_r >= fill_r) begin
          p1_nxt.status = ST_NO_TOKEN;
        end else begin
          p1_nxt.claimed_slot = rgrant[SLOT_W-1:0];
          ctoken_nxt          = ctoken_r + 1'b1;
        end
      end
      K_RELEASE_SPACES: begin
        if (rel_cnt > ctoken_r) begin
          p1_nxt.status = ST_OVER_REL;
        end else begin
          ctoken_nxt = ctoken_r - rel_cnt;
          fill_nxt   = fill_r - rel_cnt;
          rpos_nxt   = rrel;
        end
      end
      K_WRITE: begin
        if (cspace_r != '0) begin
          p1_nxt.status = ST_CLAIMS_OUT;
        end else if (fill_r >= n) begin
          p1_nxt.status = ST_NO_SPACE;
        end else begin
          mem_we   = 1'b1;
          wpos_nxt = wrap({1'b0, wpos_r} + 1'b1, n);
          fill_nxt = fill_r + 1'b1;
        end
      end
      K_READ: begin
        if (ctoken_r != '0) begin
          p1_nxt.status = ST_CLAIMS_OUT;
        end else if (fill_r == '0) begin
          p1_nxt.status = ST_NO_TOKEN;
        end else begin
          mem_re           = 1'b1;
          p1_nxt.use_rdata = 1'b1;
          rpos_nxt         = wrap({1'b0, rpos_r} + 1'b1, n);
          fill_nxt         = fill_r - 1'b1;
        end
      end
      K_STORE: begin
        mem_waddr = AW'({1'b0, slot_idx});
        mem_we    = slot_ok;
      end
      K_LOAD: begin
        mem_raddr        = AW'({1'b0, slot_idx});
        mem_re           = slot_ok;
        p1_nxt.use_rdata = slot_ok;
      end
      default: begin
        p1_nxt.status = ST_OK;
      end
    endcase
    p1_nxt.free_spaces      = n - fill_nxt - cspace_nxt;
    p1_nxt.available_tokens = fill_nxt - ctoken_nxt;
  end

  // control registers; a configuration transfer empties the fifo
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= CNT_W'(16);
      wpos_r     <= '0;
      rpos_r     <= '0;
      fill_r     <= '0;
      cspace_r   <= '0;
      ctoken_r   <= '0;
    end else if (cfg_acc) begin
      slot_cnt_r <= cfg_data;
      wpos_r     <= '0;
      rpos_r     <= '0;
      fill_r     <= '0;
      cspace_r   <= '0;
      ctoken_r   <= '0;
    end else if (in_acc) begin
      wpos_r     <= wpos_nxt;
      rpos_r     <= rpos_nxt;
      fill_r     <= fill_nxt;
      cspace_r   <= cspace_nxt;
      ctoken_r   <= ctoken_nxt;
    end
  end

  // token memory, registered read
  always_ff @(posedge clk) begin
    if (in_acc && mem_we) begin
      mem[mem_waddr] <= wdata[SB-1:0];
    end
    if (in_acc && mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // result stage waiting on the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_acc) begin
      p1_valid_r <= 1'b1;
    end else if (out_load) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_r <= p1_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'd0, p1_r.available_tokens, p1_r.free_spaces,
                     (p1_r.use_rdata ? DATA_W'(mem_q_r) : DATA_W'(0)),
                     p1_r.claimed_slot, p1_r.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_space_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_space <= {1'b0, n})
    else $error("fill plus claimed spaces exceeds slot count");

  a_token_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctoken_r <= fill_r)
    else $error("claimed tokens exceed fill count");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r < n && rpos_r < n)
    else $error("fifo position outside slot range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while result stage is blocked");
`endif

endmodule
